/* rtl/tbp_pkg.sv */
// tbp_pkg: shared types, constants and counter helpers for the tournament predictor
// used by tournament_branch_predictor; no dependencies
`default_nettype none

package tbp_pkg;

  // default table index widths
  localparam int unsigned MAX_GLOBAL_BITS_DEF = 12;
  localparam int unsigned MAX_LOCAL_BITS_DEF  = 12;
  localparam int unsigned MAX_PC_BITS_DEF     = 12;

  // configuration port
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HISTORY_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HISTORY_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PC_INDEX_BITS       = 2'd2;

  localparam logic [CFG_DATA_W-1:0] GLOBAL_HISTORY_BITS_RST = 4'd9;
  localparam logic [CFG_DATA_W-1:0] LOCAL_HISTORY_BITS_RST  = 4'd10;
  localparam logic [CFG_DATA_W-1:0] PC_INDEX_BITS_RST       = 4'd10;

  // 2-bit saturating counters
  localparam logic [1:0] CTR_ZERO    = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [1:0] CTR_MAX     = 2'd3;

  typedef struct packed {
    logic [31:0] pc;
    logic        outcome;
  } in_req_t;

  typedef struct packed {
    logic prediction;
    logic local_guess;
    logic global_guess;
    logic chose_local;
  } out_rsp_t;

  // low-bit mask for a length register, clamped to 1..maxb
  function automatic logic [15:0] width_mask(logic [CFG_DATA_W-1:0] v, int unsigned maxb);
    int unsigned n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > maxb) n = maxb;
    return 16'((32'd1 << n) - 32'd1);
  endfunction

  // move a counter toward the outcome, saturating
  function automatic logic [1:0] ctr_train(logic [1:0] c, logic taken);
    logic [1:0] r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_ZERO) r = c - 2'd1;
    end
    return r;
  endfunction

  // chooser moves only when exactly one component was right
  function automatic logic [1:0] chooser_train(logic [1:0] sel, logic lguess, logic gguess,
                                               logic taken);
    logic [1:0] r;
    r = sel;
    if (lguess == taken && gguess != taken && sel != CTR_MAX) r = sel + 2'd1;
    else if (lguess != taken && gguess == taken && sel != CTR_ZERO) r = sel - 2'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tournament_branch_predictor.sv */
// tournament_branch_predictor: local/global tournament predictor with training
// three-stage pipeline over the history and counter memories; uses tbp_pkg
//
// each result passes the stage 1, stage 2 and output registers
// throughput: one request per cycle while in_stall is low; each memory is read
// once and written once a cycle; reset clears the pipeline, then a clearing pass
// rewrites every table entry while in_stall is held high
`default_nettype none

module tournament_branch_predictor import tbp_pkg::*; #(
  parameter int unsigned MAX_GLOBAL_BITS = MAX_GLOBAL_BITS_DEF,
  parameter int unsigned MAX_LOCAL_BITS  = MAX_LOCAL_BITS_DEF,
  parameter int unsigned MAX_PC_BITS     = MAX_PC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output out_rsp_t               out_data,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned G = MAX_GLOBAL_BITS;
  localparam int unsigned L = MAX_LOCAL_BITS;
  localparam int unsigned P = MAX_PC_BITS;
  localparam int unsigned GL = (G > L) ? G : L;
  localparam int unsigned CW = (GL > P) ? GL : P;
  localparam int unsigned G_DEPTH = 1 << G;
  localparam int unsigned L_DEPTH = 1 << L;
  localparam int unsigned P_DEPTH = 1 << P;

  // memories
  logic [L-1:0] lht_mem  [P_DEPTH];
  logic [1:0]   lctr_mem [L_DEPTH];
  logic [3:0]   gmem     [G_DEPTH];   // {chooser, global counter}

  // control
  logic          clearing_r;
  logic [CW-1:0] clr_cnt_r;
  logic [G-1:0]  gmask_r;
  logic [L-1:0]  lmask_r;
  logic [P-1:0]  pmask_r;
  logic [G-1:0]  ghist_r;
  logic          s1_valid_r, s2_valid_r, out_valid_r;
  logic          adv, accept;

  // stage 0
  logic [P-1:0]  pidx0;
  logic [G-1:0]  gidx0, ghist_nxt;

  // stage 1
  logic [P-1:0]  s1_pidx_r;
  logic [G-1:0]  s1_gidx_r;
  logic          s1_outcome_r;
  logic [L-1:0]  lht_rd_r, lht_byp_data_r;
  logic          lht_byp_r;
  logic [L-1:0]  lidx1, lht_new;

  // stage 2
  logic [L-1:0]  s2_lidx_r;
  logic [G-1:0]  s2_gidx_r;
  logic          s2_outcome_r;
  logic [1:0]    lctr_rd_r, lctr_byp_data_r;
  logic          lctr_byp_r;
  logic [3:0]    gmem_rd_r, gmem_byp_data_r;
  logic          gmem_byp_r;
  logic [1:0]    lctr2, gctr2, sel2, lctr_new, gctr_new, sel_new;
  logic [3:0]    gmem_new;
  out_rsp_t      rsp2;

  out_rsp_t      out_data_r;

  // whole pipeline moves together unless the output register is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = clearing_r || !adv;
  assign accept   = in_valid && !in_stall;

  assign pidx0     = in_data.pc[P-1:0] & pmask_r;
  assign gidx0     = ghist_r & gmask_r;
  assign ghist_nxt = G'({gidx0, in_data.outcome}) & gmask_r;

  // stage 1: local history with bypass of the write issued alongside the read
  assign lidx1   = (lht_byp_r ? lht_byp_data_r : lht_rd_r) & lmask_r;
  assign lht_new = L'({lidx1, s1_outcome_r}) & lmask_r;

  // stage 2: counters and chooser
  assign lctr2 = lctr_byp_r ? lctr_byp_data_r : lctr_rd_r;
  assign gctr2 = gmem_byp_r ? gmem_byp_data_r[1:0] : gmem_rd_r[1:0];
  assign sel2  = gmem_byp_r ? gmem_byp_data_r[3:2] : gmem_rd_r[3:2];

  always_comb begin
    rsp2.local_guess  = lctr2[1];
    rsp2.global_guess = gctr2[1];
    rsp2.chose_local  = sel2[1];
    rsp2.prediction   = sel2[1] ? lctr2[1] : gctr2[1];
    lctr_new = ctr_train(lctr2, s2_outcome_r);
    gctr_new = ctr_train(gctr2, s2_outcome_r);
    sel_new  = chooser_train(sel2, lctr2[1], gctr2[1], s2_outcome_r);
    gmem_new = {sel_new, gctr_new};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      gmask_r     <= G'(width_mask(GLOBAL_HISTORY_BITS_RST, G));
      lmask_r     <= L'(width_mask(LOCAL_HISTORY_BITS_RST, L));
      pmask_r     <= P'(width_mask(PC_INDEX_BITS_RST, P));
      ghist_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
        if (&clr_cnt_r) clearing_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLOBAL_HISTORY_BITS: gmask_r <= G'(width_mask(cfg_wdata, G));
          CFG_LOCAL_HISTORY_BITS:  lmask_r <= L'(width_mask(cfg_wdata, L));
          CFG_PC_INDEX_BITS:       pmask_r <= P'(width_mask(cfg_wdata, P));
          default: ;
        endcase
      end
      if (accept) ghist_r <= ghist_nxt;
      if (adv) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pidx_r      <= pidx0;
      s1_gidx_r      <= gidx0;
      s1_outcome_r   <= in_data.outcome;
      lht_byp_r      <= s1_valid_r && (s1_pidx_r == pidx0);
      lht_byp_data_r <= lht_new;

      s2_lidx_r       <= lidx1;
      s2_gidx_r       <= s1_gidx_r;
      s2_outcome_r    <= s1_outcome_r;
      lctr_byp_r      <= s2_valid_r && (s2_lidx_r == lidx1);
      lctr_byp_data_r <= lctr_new;
      gmem_byp_r      <= s2_valid_r && (s2_gidx_r == s1_gidx_r);
      gmem_byp_data_r <= gmem_new;

      out_data_r <= rsp2;
    end
  end

  // local history table: read at request, written back from stage 1
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      lht_mem[clr_cnt_r[P-1:0]] <= '0;
    end else if (adv && s1_valid_r) begin
      lht_mem[s1_pidx_r] <= lht_new;
    end
    if (adv) lht_rd_r <= lht_mem[pidx0];
  end

  // local counters
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      lctr_mem[clr_cnt_r[L-1:0]] <= CTR_WEAK_NT;
    end else if (adv && s2_valid_r) begin
      lctr_mem[s2_lidx_r] <= lctr_new;
    end
    if (adv) lctr_rd_r <= lctr_mem[lidx1];
  end

  // global counters and chooser share the global index
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      gmem[clr_cnt_r[G-1:0]] <= {CTR_ZERO, CTR_WEAK_NT};
    end else if (adv && s2_valid_r) begin
      gmem[s2_gidx_r] <= gmem_new;
    end
    if (adv) gmem_rd_r <= gmem[s1_gidx_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
